### rtl/pidci_pkg.sv
// Shared widths and register index codes for the clamped-integral PID core.
// Depends on nothing; imported by pid_with_clamped_integral_core.
package pidci_pkg;

  localparam int VAL_W     = 16;  // goal, measured, drive, drive limits
  localparam int ERR_W     = 17;  // goal - measured
  localparam int DIFF_W    = 18;  // error - last error
  localparam int TICK_W    = 32;
  localparam int GAIN_W    = 32;
  localparam int LIM_W     = 32;  // integral limits and clamped integral
  localparam int INTEG_W   = 40;  // stored integral
  localparam int INC_W     = 49;  // error * elapsed
  localparam int SUM_W     = 50;  // integral + increment
  localparam int TB_W      = 52;  // integral after take-back, before saturation
  localparam int MUL_W     = 33;  // shared multiplier operand width
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DPROD_W   = 50;  // derivative numerator, signed
  localparam int DIV_W     = 48;  // derivative numerator magnitude
  localparam int DCNT_W    = 6;
  localparam int ACC_W     = 64;  // P + I + D
  localparam int CS_W      = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int S_DATA_W  = 48;  // measured, time_tick
  localparam int M_DATA_W  = 24;  // drive, clamp_state, zero fill

  localparam logic [CFG_IDX_W-1:0] REG_GOAL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRV_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRV_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KI       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTG_MAX = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INTG_MIN = 3'd7;

  localparam logic [CS_W-1:0] CLAMP_NONE = 2'b00;
  localparam logic [CS_W-1:0] CLAMP_HIGH = 2'b01;
  localparam logic [CS_W-1:0] CLAMP_LOW  = 2'b10;
  localparam logic [CS_W-1:0] CLAMP_BOTH = 2'b11;

  localparam logic signed [TB_W-1:0] INTEG_MAX_V = TB_W'(64'sd549755813887);
  localparam logic signed [TB_W-1:0] INTEG_MIN_V = TB_W'(-64'sd549755813888);

  typedef logic signed [ERR_W-1:0]  err_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [MUL_W-1:0]  mul_op_t;

endpackage

### rtl/pid_with_clamped_integral_core.sv
// PID controller with clamped integral, drive clamp and anti-windup take-back.
// An accepted item passes through the states around the shared 33x33 multiplier,
// then the one-bit-a-cycle divider, then the steps that accumulate, clamp and
// store. A new item is taken only in idle, after the last result is stored; an untaken
// result holds the store step. Synchronous reset restores the configuration
// defaults and clears the integral, last error and last tick. Uses pidci_pkg.
module pid_with_clamped_integral_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // measured [15:0], time_tick [47:16]
  input  logic [pidci_pkg::S_DATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // drive [15:0], clamp_state [17:16], zero [23:18]
  output logic [pidci_pkg::M_DATA_W-1:0]      m_tdata,
  input  logic                                cfg_wr_en,
  input  logic [pidci_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pidci_pkg::CFG_W-1:0]         cfg_data
);
  import pidci_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_INC    = 4'd1;
  localparam logic [3:0] ST_SUM    = 4'd2;
  localparam logic [3:0] ST_CLAMP  = 4'd3;
  localparam logic [3:0] ST_DIVSET = 4'd4;
  localparam logic [3:0] ST_IACC   = 4'd5;
  localparam logic [3:0] ST_DIV    = 4'd6;
  localparam logic [3:0] ST_DACC   = 4'd7;
  localparam logic [3:0] ST_LIMIT  = 4'd8;
  localparam logic [3:0] ST_STORE  = 4'd9;

  localparam int SC_PAD = ACC_W - VAL_W - FRAC_BITS;

  logic [3:0] state;

  logic signed [VAL_W-1:0]   goal, drive_max, drive_min;
  logic signed [GAIN_W-1:0]  kp_gain, ki_gain, kd_gain;
  logic signed [LIM_W-1:0]   integral_max, integral_min;

  logic signed [INTEG_W-1:0] integral_sum;
  err_t                      last_error;
  logic [TICK_W-1:0]         last_tick;

  err_t                      err;
  logic signed [DIFF_W-1:0]  diff;
  logic [TICK_W-1:0]         tick;
  logic [TICK_W-1:0]         elapsed;
  logic signed [INC_W-1:0]   inc;
  logic signed [SUM_W-1:0]   sum;
  logic signed [LIM_W-1:0]   integ;
  logic signed [PROD_W-1:0]  prod;
  acc_t                      acc;
  logic [DIV_W-1:0]          dq;
  logic [TICK_W-1:0]         rem;
  logic                      dneg;
  logic [DCNT_W-1:0]         dcnt;
  logic signed [VAL_W-1:0]   drv;
  logic [CS_W-1:0]           cs;

  mul_op_t                   mul_a, mul_b;
  err_t                      meas_err;
  logic [TICK_W-1:0]         tick_diff;
  logic signed [SUM_W-1:0]   sum_next;
  logic signed [LIM_W-1:0]   integ_next;
  logic signed [SUM_W-1:0]   integ_hi;
  logic signed [DPROD_W-1:0] dprod;
  logic [DPROD_W-1:0]        dmag;
  logic [TICK_W:0]           rem_sh;
  logic                      q_bit;
  logic signed [DIV_W:0]     quo;
  acc_t                      dmax_sc, dmin_sc, acc_rnd;
  logic                      hi, lo;
  logic signed [TB_W-1:0]    tb_base, tb_inc, tb_val;
  logic signed [INTEG_W-1:0] integ_sat;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_INC: begin
        mul_a = MUL_W'(err);
        mul_b = {1'b0, elapsed};
      end
      ST_SUM: begin
        mul_a = MUL_W'(kp_gain);
        mul_b = MUL_W'(err);
      end
      ST_CLAMP: begin
        mul_a = MUL_W'(kd_gain);
        mul_b = MUL_W'(diff);
      end
      ST_DIVSET: begin
        mul_a = MUL_W'(ki_gain);
        mul_b = MUL_W'(integ);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    meas_err  = ERR_W'($signed(goal)) - ERR_W'($signed(s_tdata[VAL_W-1:0]));
    tick_diff = s_tdata[S_DATA_W-1:VAL_W] - last_tick;

    sum_next   = SUM_W'(integral_sum) + SUM_W'($signed(prod[INC_W-1:0]));
    integ_hi   = (sum > SUM_W'(integral_max)) ? SUM_W'(integral_max) : sum;
    integ_next = (integ_hi < SUM_W'(integral_min)) ? integral_min
                                                   : integ_hi[LIM_W-1:0];

    dprod  = prod[DPROD_W-1:0];
    dmag   = dprod[DPROD_W-1] ? DPROD_W'(-dprod) : DPROD_W'(dprod);
    rem_sh = {rem, dq[DIV_W-1]};
    q_bit  = (rem_sh >= {1'b0, elapsed});
    quo    = dneg ? -$signed({1'b0, dq}) : $signed({1'b0, dq});

    dmax_sc = {{SC_PAD{drive_max[VAL_W-1]}}, drive_max, {FRAC_BITS{1'b0}}};
    dmin_sc = {{SC_PAD{drive_min[VAL_W-1]}}, drive_min, {FRAC_BITS{1'b0}}};
    hi      = (acc > dmax_sc);
    lo      = hi ? (drive_max < drive_min) : (acc < dmin_sc);
    acc_rnd = acc + (acc[ACC_W-1] ? {{(ACC_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}}
                                  : '0);

    tb_base = TB_W'(integ);
    case (cs) inside
      CLAMP_BOTH:             tb_inc = TB_W'(inc) <<< 1;
      CLAMP_HIGH, CLAMP_LOW:  tb_inc = TB_W'(inc);
      default:                tb_inc = '0;
    endcase
    tb_val = tb_base - tb_inc;
    if (tb_val > INTEG_MAX_V) begin
      integ_sat = INTEG_MAX_V[INTEG_W-1:0];
    end else if (tb_val < INTEG_MIN_V) begin
      integ_sat = INTEG_MIN_V[INTEG_W-1:0];
    end else begin
      integ_sat = tb_val[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      goal         <= '0;
      drive_max    <= 16'sh7FFF;
      drive_min    <= 16'sh8000;
      kp_gain      <= '0;
      ki_gain      <= '0;
      kd_gain      <= '0;
      integral_max <= 32'sh7FFF_FFFF;
      integral_min <= 32'sh8000_0000;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GOAL:     goal         <= cfg_data[VAL_W-1:0];
        REG_DRV_MAX:  drive_max    <= cfg_data[VAL_W-1:0];
        REG_DRV_MIN:  drive_min    <= cfg_data[VAL_W-1:0];
        REG_KP:       kp_gain      <= cfg_data;
        REG_KI:       ki_gain      <= cfg_data;
        REG_KD:       kd_gain      <= cfg_data;
        REG_INTG_MAX: integral_max <= cfg_data;
        REG_INTG_MIN: integral_min <= cfg_data;
        default:      goal         <= goal;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      integral_sum <= '0;
      last_error   <= '0;
      last_tick    <= '0;
      m_tvalid     <= 1'b0;
      dcnt         <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_STORE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            err     <= meas_err;
            tick    <= s_tdata[S_DATA_W-1:VAL_W];
            elapsed <= (tick_diff == '0) ? TICK_W'(1) : tick_diff;
            state   <= ST_INC;
          end
        end
        ST_INC: begin
          diff  <= DIFF_W'(err) - DIFF_W'(last_error);
          state <= ST_SUM;
        end
        ST_SUM: begin
          inc   <= prod[INC_W-1:0];
          sum   <= sum_next;
          state <= ST_CLAMP;
        end
        ST_CLAMP: begin
          integ <= integ_next;
          acc   <= prod[ACC_W-1:0];
          state <= ST_DIVSET;
        end
        ST_DIVSET: begin
          dneg  <= dprod[DPROD_W-1];
          dq    <= dmag[DIV_W-1:0];
          rem   <= '0;
          dcnt  <= '0;
          state <= ST_IACC;
        end
        ST_IACC: begin
          acc   <= acc + prod[ACC_W-1:0];
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem  <= q_bit ? TICK_W'(rem_sh - {1'b0, elapsed}) : rem_sh[TICK_W-1:0];
          dq   <= {dq[DIV_W-2:0], q_bit};
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCNT_W'(DIV_W - 1)) begin
            state <= ST_DACC;
          end
        end
        ST_DACC: begin
          acc   <= acc + ACC_W'(quo);
          state <= ST_LIMIT;
        end
        ST_LIMIT: begin
          cs <= {lo, hi};
          if (lo) begin
            drv <= drive_min;
          end else if (hi) begin
            drv <= drive_max;
          end else begin
            drv <= acc_rnd[FRAC_BITS +: VAL_W];
          end
          state <= ST_STORE;
        end
        ST_STORE: begin
          if (!m_tvalid || m_tready) begin
            integral_sum <= integ_sat;
            last_error   <= err;
            last_tick    <= tick;
            m_tdata      <= {{(M_DATA_W-VAL_W-CS_W){1'b0}}, cs, drv};
            m_tvalid     <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
